### rtl/pbnf_pkg.sv
// Shared types, constants and the exp(-x) table generator for the bilateral normal filter.
`timescale 1ns / 1ps
package pbnf_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int EXP_ENTRIES = 256;
	localparam int EXP_BITS    = $clog2(EXP_ENTRIES);
	// lookup index = floor(arg * EXP_ENTRIES / 2^(FRAC_BITS+3))
	localparam int IDX_LSB     = FRAC_BITS + 3 - EXP_BITS;

	localparam logic [1:0] CFG_SPATIAL  = 2'd0;
	localparam logic [1:0] CFG_RANGE    = 2'd1;
	localparam logic [1:0] CFG_EXTENDED = 2'd2;

	localparam logic [23:0] GAIN_RESET = 24'd65536;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef logic signed [17:0] coord_t;

	typedef struct packed {
		logic            center;
		logic            last;
		coord_t [2:0]    pos;
		coord_t [2:0]    nrm;
	} item_t;

	typedef struct packed {
		logic            saturated;
		logic            empty_weight;
		coord_t [2:0]    new_pos;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [23:0] data;
	} cfg_wr_t;

	// exp(-f) for f in [0, 1] in Q30, Taylor series
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
		logic signed [63:0] acc;
		logic [63:0]        term;
		int                 k;
		acc  = 64'sd0;
		term = Q30_ONE;
		for (k = 0; k < 32; k++) begin
			if (term != 64'd0) begin
				if (k[0])
					acc = acc - $signed(term);
				else
					acc = acc + $signed(term);
				term = ((term * f) >> 30) / 64'(k + 1);
			end
		end
		return (acc < 0) ? 64'd0 : 64'(acc);
	endfunction

	// entry i = exp(-8 i / EXP_ENTRIES) in Q0.16, capped at 0xFFFF
	function automatic logic [15:0] exp_entry(input int idx);
		logic [63:0] e1;
		logic [63:0] x;
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] v;
		int          j;
		e1 = exp_neg_q30(Q30_ONE);
		x  = (64'(idx) << 33) / 64'(EXP_ENTRIES);
		n  = x >> 30;
		r  = exp_neg_q30(x & (Q30_ONE - 64'd1));
		for (j = 0; j < 8; j++) begin
			if (64'(j) < n)
				r = (r * e1) >> 30;
		end
		v = (r + 64'd8192) >> 14;
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

### rtl/pbnf_front.sv
// Input side: accepts stream items, tags center or neighbor, and queues them for the back end.
`timescale 1ns / 1ps
module pbnf_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_action,
	input  logic            in_last,
	input  pbnf_pkg::coord_t [2:0] in_pos,
	input  pbnf_pkg::coord_t [2:0] in_nrm,
	input  logic            pop,
	output logic            q_valid,
	output pbnf_pkg::item_t q_item
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	pbnf_pkg::item_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            do_pop;
	pbnf_pkg::item_t entry;

	always_comb begin
		entry.center = ~in_action;
		entry.last   = in_last;
		entry.pos    = in_pos;
		entry.nrm    = in_nrm;
	end

	assign in_ready = (cnt_q != CW'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid & in_ready;
	assign do_pop   = pop & q_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/pbnf_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module pbnf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [41:0] radicand,
	output logic        done,
	output logic [20:0] root
);
	logic [41:0] v_q;
	logic [41:0] r_q;
	logic [41:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [41:0] trial;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[20:0];

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= 42'd1 << 40;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd20;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/pbnf_divider.sv
// Restoring divider, one quotient bit per cycle: 48-bit magnitude by 40-bit divisor.
`timescale 1ns / 1ps
module pbnf_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [39:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);
	logic [47:0] quo_q;
	logic [40:0] rem_q;
	logic [39:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [40:0] rem_sh;
	logic        fits;

	assign rem_sh   = {rem_q[39:0], quo_q[47]};
	assign fits     = (rem_sh >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[46:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/pbnf_back.sv
// Back end: weight sequencer on one shared multiplier, accumulators, emit path, output register.
`timescale 1ns / 1ps
module pbnf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pbnf_pkg::cfg_wr_t cfg,
	input  logic              q_valid,
	input  pbnf_pkg::item_t   q_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output pbnf_pkg::result_t out_res
);
	localparam int F = pbnf_pkg::FRAC_BITS;

	localparam logic [5:0] S_IDLE = 6'd0,  S_D0  = 6'd1,  S_D1  = 6'd2,  S_D2  = 6'd3;
	localparam logic [5:0] S_N0   = 6'd4,  S_N1  = 6'd5,  S_N2  = 6'd6,  S_DOT = 6'd7;
	localparam logic [5:0] S_HH   = 6'd8,  S_SS  = 6'd9,  S_SR  = 6'd10, S_LR  = 6'd11;
	localparam logic [5:0] S_WW   = 6'd12, S_W   = 6'd13, S_C0  = 6'd14, S_C1  = 6'd15;
	localparam logic [5:0] S_C2   = 6'd16, S_C3  = 6'd17, S_C4  = 6'd18, S_C5  = 6'd19;
	localparam logic [5:0] S_C6   = 6'd20, S_Q0  = 6'd21, S_Q1  = 6'd22, S_Q2  = 6'd23;
	localparam logic [5:0] S_Q3   = 6'd24, S_SQ  = 6'd25, S_SQW = 6'd26, S_WF  = 6'd27;
	localparam logic [5:0] S_WX   = 6'd28, S_AH  = 6'd29, S_AC  = 6'd30, S_EMIT = 6'd31;
	localparam logic [5:0] S_DIVW = 6'd32, S_X0  = 6'd33, S_X1  = 6'd34, S_X2  = 6'd35;
	localparam logic [5:0] S_X3   = 6'd36, S_OUT = 6'd37;

	localparam logic [34:0] ARG_LIM  = 35'd8 << F;
	localparam logic [47:0] DISP_LIM = 48'd1 << 45;

	// config
	logic [23:0] spatial_q;
	logic [23:0] range_q;
	logic        ext_q;

	logic [5:0]  st_q;
	logic [1:0]  k_q;

	logic signed [17:0] cp_q [3];
	logic signed [17:0] cn_q [3];
	logic signed [17:0] m_q  [3];
	logic signed [18:0] d_q  [3];
	logic signed [20:0] cf_q [3];
	logic signed [17:0] res_q [3];
	logic               last_q;
	logic [37:0]        t2_q;
	logic signed [37:0] dot_q;
	logic signed [21:0] hf_q;
	logic [25:0]        sqr_q;
	logic [15:0]        ws_q;
	logic [15:0]        wr_q;
	logic [15:0]        w_q;
	logic signed [35:0] ta_q;
	logic [41:0]        s_q;
	logic [16:0]        fac_q;
	logic signed [47:0] whs_q;
	logic [39:0]        wsum_q;
	logic               neg_q;
	logic signed [46:0] disp_q;
	logic signed [42:0] plo_q;
	logic signed [47:0] t_q;
	logic               sat_q;
	logic               emp_q;

	logic signed [26:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [51:0] prod_q;

	logic                out_valid_q;
	pbnf_pkg::result_t   out_q;

	logic [15:0]        exp_tab [pbnf_pkg::EXP_ENTRIES];
	logic [34:0]        lut_arg;
	logic [15:0]        lut_val;
	logic signed [21:0] hf;
	logic signed [36:0] cdiff;
	logic signed [48:0] hsum;
	logic [40:0]        wsum_nx;
	logic               isq_start;
	logic               isq_done;
	logic [20:0]        isq_root;
	logic               div_start;
	logic               div_done;
	logic [47:0]        div_quo;
	logic [47:0]        div_num;
	logic [45:0]        qclamp;
	logic signed [63:0] full;
	logic signed [48:0] vdiff;
	logic               out_load;

	for (genvar g = 0; g < pbnf_pkg::EXP_ENTRIES; g++) begin : g_tab
		assign exp_tab[g] = pbnf_pkg::exp_entry(g);
	end

	assign lut_arg = prod_q[50:F];
	assign lut_val = (lut_arg >= ARG_LIM) ? 16'd0 :
		exp_tab[lut_arg[pbnf_pkg::IDX_LSB + pbnf_pkg::EXP_BITS - 1:pbnf_pkg::IDX_LSB]];
	assign hf      = $signed(dot_q[37:F]);
	assign cdiff   = 37'(ta_q) - 37'($signed(prod_q[35:0]));
	assign hsum    = 49'(whs_q) + $signed(prod_q[48:0]);
	assign wsum_nx = {1'b0, wsum_q} + 41'(w_q);
	assign div_num = whs_q[47] ? 48'(-whs_q) : 48'(whs_q);
	assign qclamp  = (div_quo > DISP_LIM) ? 46'(DISP_LIM) : div_quo[45:0];
	assign full    = (64'($signed(prod_q[40:0])) <<< 24) + 64'(plo_q);
	assign vdiff   = 49'(cp_q[k_q]) - 49'(t_q);

	assign isq_start = (st_q == S_SQ);
	assign div_start = (st_q == S_EMIT) && (wsum_q != '0);
	assign pop       = (st_q == S_IDLE) && q_valid;
	assign out_load  = (st_q == S_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	pbnf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (isq_start),
		.radicand (s_q),
		.done     (isq_done),
		.root     (isq_root)
	);

	pbnf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (wsum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_D0: begin mul_a = 27'(d_q[0]);  mul_b = 25'(d_q[0]); end
			S_D1: begin mul_a = 27'(d_q[1]);  mul_b = 25'(d_q[1]); end
			S_D2: begin mul_a = 27'(d_q[2]);  mul_b = 25'(d_q[2]); end
			S_N0: begin mul_a = 27'(cn_q[0]); mul_b = 25'(d_q[0]); end
			S_N1: begin mul_a = 27'(cn_q[1]); mul_b = 25'(d_q[1]); end
			S_N2: begin mul_a = 27'(cn_q[2]); mul_b = 25'(d_q[2]); end
			S_HH: begin mul_a = 27'(hf);      mul_b = 25'(hf); end
			S_SS: begin mul_a = 27'(t2_q[37:F]); mul_b = 25'(spatial_q); end
			S_SR: begin mul_a = 27'(sqr_q);   mul_b = 25'(range_q); end
			S_WW: begin mul_a = 27'(ws_q);    mul_b = 25'(wr_q); end
			S_C0: begin mul_a = 27'(m_q[1]);  mul_b = 25'(cn_q[2]); end
			S_C1: begin mul_a = 27'(m_q[2]);  mul_b = 25'(cn_q[1]); end
			S_C2: begin mul_a = 27'(m_q[2]);  mul_b = 25'(cn_q[0]); end
			S_C3: begin mul_a = 27'(m_q[0]);  mul_b = 25'(cn_q[2]); end
			S_C4: begin mul_a = 27'(m_q[0]);  mul_b = 25'(cn_q[1]); end
			S_C5: begin mul_a = 27'(m_q[1]);  mul_b = 25'(cn_q[0]); end
			S_Q0: begin mul_a = 27'(cf_q[0]); mul_b = 25'(cf_q[0]); end
			S_Q1: begin mul_a = 27'(cf_q[1]); mul_b = 25'(cf_q[1]); end
			S_Q2: begin mul_a = 27'(cf_q[2]); mul_b = 25'(cf_q[2]); end
			S_WF: begin mul_a = 27'(w_q);     mul_b = 25'(fac_q); end
			S_AH: begin mul_a = 27'(w_q);     mul_b = 25'(hf_q); end
			S_X0: begin mul_a = 27'(cn_q[k_q]); mul_b = 25'(disp_q[23:0]); end
			S_X1: begin mul_a = 27'(cn_q[k_q]); mul_b = 25'($signed(disp_q[46:24])); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					for (int i = 0; i < 3; i++) begin
						d_q[i] <= 19'(cp_q[i]) - 19'(q_item.pos[i]);
						m_q[i] <= q_item.nrm[i];
					end
					last_q <= q_item.last;
				end
			end
			S_D1:  t2_q  <= prod_q[37:0];
			S_D2:  t2_q  <= t2_q + prod_q[37:0];
			S_N0:  t2_q  <= t2_q + prod_q[37:0];
			S_N1:  dot_q <= $signed(prod_q[37:0]);
			S_N2:  dot_q <= dot_q + $signed(prod_q[37:0]);
			S_DOT: dot_q <= dot_q + $signed(prod_q[37:0]);
			S_HH:  hf_q  <= hf;
			S_SS:  sqr_q <= prod_q[41:F];
			S_SR:  ws_q  <= lut_val;
			S_LR:  wr_q  <= lut_val;
			S_W:   w_q   <= prod_q[31:F];
			S_C1:  ta_q  <= $signed(prod_q[35:0]);
			S_C2:  cf_q[0] <= cdiff[36:F];
			S_C3:  ta_q  <= $signed(prod_q[35:0]);
			S_C4:  cf_q[1] <= cdiff[36:F];
			S_C5:  ta_q  <= $signed(prod_q[35:0]);
			S_C6:  cf_q[2] <= cdiff[36:F];
			S_Q1:  s_q   <= prod_q[41:0];
			S_Q2:  s_q   <= s_q + prod_q[41:0];
			S_Q3:  s_q   <= s_q + prod_q[41:0];
			S_SQW: fac_q <= (isq_root < 21'(1 << F)) ? 17'(21'(1 << F) - isq_root) : '0;
			S_WX:  w_q   <= prod_q[31:F];
			S_EMIT: begin
				neg_q <= whs_q[47];
				sat_q <= 1'b0;
				emp_q <= (wsum_q == '0);
				if (wsum_q == '0) begin
					for (int i = 0; i < 3; i++)
						res_q[i] <= cp_q[i];
				end
			end
			S_DIVW: disp_q <= neg_q ? -47'(qclamp) : 47'(qclamp);
			S_X1:   plo_q  <= $signed(prod_q[42:0]);
			S_X2:   t_q    <= full[63:F];
			S_X3: begin
				if (vdiff > 49'sd131071) begin
					res_q[k_q] <= 18'sh1FFFF;
					sat_q      <= 1'b1;
				end else if (vdiff < -49'sd131072) begin
					res_q[k_q] <= -18'sh20000;
					sat_q      <= 1'b1;
				end else begin
					res_q[k_q] <= vdiff[17:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.saturated    <= sat_q;
			out_q.empty_weight <= emp_q;
			for (int i = 0; i < 3; i++)
				out_q.new_pos[i] <= res_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spatial_q   <= pbnf_pkg::GAIN_RESET;
			range_q     <= pbnf_pkg::GAIN_RESET;
			ext_q       <= 1'b0;
			st_q        <= S_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			whs_q       <= '0;
			wsum_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				cp_q[i] <= '0;
				cn_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					pbnf_pkg::CFG_SPATIAL:  spatial_q <= cfg.data;
					pbnf_pkg::CFG_RANGE:    range_q   <= cfg.data;
					pbnf_pkg::CFG_EXTENDED: ext_q     <= cfg.data[0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.center) begin
							for (int i = 0; i < 3; i++) begin
								cp_q[i] <= q_item.pos[i];
								cn_q[i] <= q_item.nrm[i];
							end
							whs_q  <= '0;
							wsum_q <= '0;
							if (q_item.last)
								st_q <= S_EMIT;
						end else begin
							st_q <= S_D0;
						end
					end
				end
				S_W:   st_q <= ext_q ? S_C0 : S_AH;
				S_SQW: if (isq_done) st_q <= S_WF;
				S_AC: begin
					if (hsum[48] != hsum[47])
						whs_q <= hsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
					else
						whs_q <= hsum[47:0];
					wsum_q <= wsum_nx[40] ? '1 : wsum_nx[39:0];
					st_q   <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: st_q <= (wsum_q == '0) ? S_OUT : S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						k_q  <= '0;
						st_q <= S_X0;
					end
				end
				S_X3: begin
					if (k_q == 2'd2) begin
						st_q <= S_OUT;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_X0;
					end
				end
				S_OUT: begin
					if (out_load) begin
						whs_q  <= '0;
						wsum_q <= '0;
						st_q   <= S_IDLE;
					end
				end
				default: st_q <= st_q + 1'b1;
			endcase
		end
	end

endmodule

### rtl/point_bilateral_normal_filter_top.sv
// Neighbor items run the shared multiplier sequence, and in extended mode also the
// 21-step square root; items are worked one at a time.
// If weight was summed, a last item adds the 48-step divider and the three coordinate updates.
// Up to QUEUE_DEPTH items are taken while the back end is busy; one result waits in the
// output register without stopping work on the next items.
// Reset clears config to defaults, center and accumulators to zero, queue and output empty.
`timescale 1ns / 1ps
module point_bilateral_normal_filter_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, 4'b0
	input  logic [0:0]   s_axis_tuser,  // action
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,  // new_x, new_y, new_z, 2'b0
	output logic [1:0]   m_axis_tuser,  // empty_weight, saturated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	pbnf_pkg::coord_t [2:0] in_pos;
	pbnf_pkg::coord_t [2:0] in_nrm;
	pbnf_pkg::item_t        q_item;
	pbnf_pkg::result_t      res;
	pbnf_pkg::cfg_wr_t      cfg;
	logic                   q_valid;
	logic                   pop;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i] = s_axis_tdata[18*i +: 18];
			in_nrm[i] = s_axis_tdata[54 + 18*i +: 18];
		end
		cfg.valid = cfg_valid;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {2'b00, res.new_pos[2], res.new_pos[1], res.new_pos[0]};
	assign m_axis_tuser = {res.saturated, res.empty_weight};

	pbnf_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser[0]),
		.in_last   (s_axis_tlast),
		.in_pos    (in_pos),
		.in_nrm    (in_nrm),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	pbnf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

endmodule

### rtl/pbnf_checker.sv
// Port-level checks for the bilateral normal filter, bound to the top level.
`timescale 1ns / 1ps
module pbnf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// at most two result transfers back to back: the waiting one and the one behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) ##1 (m_axis_tvalid && m_axis_tready) |=>
			!m_axis_tvalid)
		else $error("results produced too close together");

	// an empty-weight result is never flagged saturated (the center passes through unclamped)
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("empty result flagged as saturated");

endmodule

bind point_bilateral_normal_filter_top pbnf_checker u_pbnf_checker (.*);
